/* sv/rgbup_pkg.sv */
// Shared types, constants and channel arithmetic for the 2x linear RGB upscaler.
`default_nettype none

package rgbup_pkg;

    // Largest source image; the line store is sized for its width.
    localparam int unsigned MAX_WIDTH  = 1024;
    localparam int unsigned MAX_HEIGHT = 1024;

    // One expanded row holds two entries per source column.
    localparam int unsigned LINE_DEPTH = 2 * MAX_WIDTH;
    localparam int unsigned X_W        = $clog2(LINE_DEPTH);
    localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
    localparam int unsigned ROW_W      = $clog2(MAX_HEIGHT);
    localparam int unsigned Y_W        = ROW_W + 1;

    // Fixed field widths of the channels and registers.
    localparam int unsigned DIM_W   = 11;
    localparam int unsigned COORD_W = 11;
    localparam int unsigned CH_W    = 8;
    localparam int unsigned PIX_W   = 3 * CH_W;

    // Configuration register indexes.
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(1024);
    localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(1024);

    typedef logic [PIX_W-1:0] t_pixel;

    typedef struct packed {
        logic [CH_W-1:0] in_red;
        logic [CH_W-1:0] in_green;
        logic [CH_W-1:0] in_blue;
    } t_in_item;

    typedef struct packed {
        logic [COORD_W-1:0] out_col;
        logic [COORD_W-1:0] out_row;
        logic [CH_W-1:0]    out_red;
        logic [CH_W-1:0]    out_green;
        logic [CH_W-1:0]    out_blue;
        logic               run_last;
    } t_out_item;

    // Per channel floor(a/2) + floor(b/2); the sum never exceeds 254.
    function automatic t_pixel half_sum(input t_pixel a, input t_pixel b);
        t_pixel res;
        for (int i = 0; i < 3; i++) begin
            res[i*CH_W +: CH_W] = {1'b0, a[i*CH_W+1 +: CH_W-1]}
                                + {1'b0, b[i*CH_W+1 +: CH_W-1]};
        end
        return res;
    endfunction

    // Register value 0 acts as 1; values above the maximum clamp to it.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] value,
                                                 input int unsigned max_v);
        logic [DIM_W-1:0] res;
        if (value == '0) begin
            res = DIM_W'(1);
        end else if (32'(value) > max_v) begin
            res = DIM_W'(max_v);
        end else begin
            res = value;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* sv/rgbup_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module rgbup_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* sv/rgb_upscale_2x_linear.sv */
// Top level of the 2x linear RGB upscaler with its line store and result sequencer.
// The item registers capture an accepted item; its results then pass through the output register.
// Throughput: one result per cycle, set by the single output register, while i_stall lets
// it drain; an item gives 1 to 9 results, 4 in the image interior (2 columns x 2 rows).
// The next item is accepted in the cycle that emits the last result of the current one.
// Reset (synchronous, active low): sizes 1024x1024, position and previous pixel zero.
`default_nettype none

module rgb_upscale_2x_linear (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire rgbup_pkg::t_in_item           i_item,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output rgbup_pkg::t_out_item               o_item,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_index,
    input  wire logic [rgbup_pkg::DIM_W-1:0]   i_cfg_data
);

    // Which expanded column of the current source pixel is being emitted:
    // the one between the previous pixel and this one, the copy, or the
    // extra column after the last source column.
    typedef enum logic [1:0] {COL_LEFT, COL_MID, COL_RIGHT} t_col_sel;
    // Which output row of the expanded column: averaged with the row above,
    // the copy, or the extra row after the last source row.
    typedef enum logic [1:0] {ROW_UP, ROW_MID, ROW_DOWN} t_row_sel;

    // Configuration and stream position.
    logic [rgbup_pkg::DIM_W-1:0] r_image_width;
    logic [rgbup_pkg::DIM_W-1:0] r_image_height;
    logic [rgbup_pkg::COL_W-1:0] r_src_col;
    logic [rgbup_pkg::ROW_W-1:0] r_src_row;
    rgbup_pkg::t_pixel           r_prev_pixel;

    // The item being expanded.
    logic                        r_busy;
    t_col_sel                    r_col_sel;
    t_row_sel                    r_row_sel;
    rgbup_pkg::t_pixel           r_cur;
    rgbup_pkg::t_pixel           r_prev;
    logic [rgbup_pkg::COL_W-1:0] r_col;
    logic [rgbup_pkg::ROW_W-1:0] r_row;
    logic                        r_has_up;
    logic                        r_is_last_col;
    logic                        r_is_last_row;

    // Output register.
    logic                        r_out_valid;
    rgbup_pkg::t_out_item        r_out;

    logic [rgbup_pkg::DIM_W-1:0] w_eff;
    logic [rgbup_pkg::DIM_W-1:0] h_eff;
    logic [rgbup_pkg::COL_W-1:0] pos_col;
    logic [rgbup_pkg::ROW_W-1:0] pos_row;
    logic [rgbup_pkg::X_W-1:0]   start_x;
    logic                        accept;
    logic                        adv;
    logic                        step;
    logic                        row_last;
    logic                        col_last;
    t_row_sel                    row_first;
    logic [rgbup_pkg::X_W-1:0]   cur_x;
    logic [rgbup_pkg::X_W-1:0]   next_x;
    rgbup_pkg::t_pixel           cur_v;
    logic [rgbup_pkg::Y_W-1:0]   base_y;
    logic [rgbup_pkg::Y_W-1:0]   cur_y;
    rgbup_pkg::t_pixel           res_pix;
    rgbup_pkg::t_pixel           above;
    logic                        ram_we;
    logic                        ram_re;
    logic [rgbup_pkg::X_W-1:0]   ram_raddr;
    rgbup_pkg::t_out_item        result;

    // Effective image size and the position the next item lands on. A
    // position left behind by a shrunk image restarts at zero.
    always_comb begin
        w_eff   = rgbup_pkg::eff_dim(r_image_width, rgbup_pkg::MAX_WIDTH);
        h_eff   = rgbup_pkg::eff_dim(r_image_height, rgbup_pkg::MAX_HEIGHT);
        pos_col = (32'(r_src_col) >= 32'(w_eff)) ? '0 : r_src_col;
        pos_row = (32'(r_src_row) >= 32'(h_eff)) ? '0 : r_src_row;
        // First expanded column of the incoming pixel; its line store entry
        // is read at the accept edge so the data is ready for the first result.
        if (pos_col != '0) begin
            start_x = {pos_col, 1'b0} - rgbup_pkg::X_W'(1);
        end else begin
            start_x = {pos_col, 1'b0};
        end
    end

    // Sequencer step: one result per cycle whenever the output register
    // is free or being emptied.
    always_comb begin
        adv       = !r_out_valid || !i_stall;
        step      = r_busy && adv;
        row_first = r_has_up ? ROW_UP : ROW_MID;
        row_last  = (r_row_sel == ROW_DOWN) || (r_row_sel == ROW_MID && !r_is_last_row);
        col_last  = (r_col_sel == COL_RIGHT) || (r_col_sel == COL_MID && !r_is_last_col);
        o_stall   = r_busy && !(adv && row_last && col_last);
        accept    = i_valid && !o_stall;

        case (r_col_sel)
            COL_LEFT: begin
                cur_x = {r_col, 1'b0} - rgbup_pkg::X_W'(1);
                cur_v = rgbup_pkg::half_sum(r_prev, r_cur);
            end
            COL_RIGHT: begin
                cur_x = {r_col, 1'b1};
                cur_v = rgbup_pkg::half_sum(r_cur, r_cur);
            end
            default: begin
                cur_x = {r_col, 1'b0};
                cur_v = r_cur;
            end
        endcase
        // The column after the current one within the same item.
        next_x = {r_col, (r_col_sel == COL_MID)};

        base_y = {r_row, 1'b0};
        case (r_row_sel)
            ROW_UP: begin
                cur_y   = base_y - rgbup_pkg::Y_W'(1);
                res_pix = rgbup_pkg::half_sum(above, cur_v);
            end
            ROW_DOWN: begin
                cur_y   = {r_row, 1'b1};
                res_pix = rgbup_pkg::half_sum(cur_v, cur_v);
            end
            default: begin
                cur_y   = base_y;
                res_pix = cur_v;
            end
        endcase

        result.out_col   = rgbup_pkg::COORD_W'(cur_x);
        result.out_row   = rgbup_pkg::COORD_W'(cur_y);
        result.out_red   = res_pix[2*rgbup_pkg::CH_W +: rgbup_pkg::CH_W];
        result.out_green = res_pix[rgbup_pkg::CH_W +: rgbup_pkg::CH_W];
        result.out_blue  = res_pix[0 +: rgbup_pkg::CH_W];
        result.run_last  = row_last && col_last;

        // The expanded pixel is written back in the first row step of its
        // column, after its old value was used for the row above. The next
        // column's entry is read in the last row step so it is ready next cycle.
        ram_we    = step && (r_row_sel == row_first);
        ram_re    = accept || (step && row_last && !col_last);
        ram_raddr = accept ? start_x : next_x;
    end

    rgbup_ram #(
        .WIDTH (rgbup_pkg::PIX_W),
        .DEPTH (rgbup_pkg::LINE_DEPTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (cur_x),
        .i_wdata (cur_v),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (above)
    );

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= rgbup_pkg::WIDTH_RESET;
            r_image_height <= rgbup_pkg::HEIGHT_RESET;
            r_src_col      <= '0;
            r_src_row      <= '0;
            r_prev_pixel   <= '0;
            r_busy         <= 1'b0;
            r_col_sel      <= COL_MID;
            r_row_sel      <= ROW_MID;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    rgbup_pkg::REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                    rgbup_pkg::REG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                    default: ;
                endcase
            end

            if (adv) begin
                r_out_valid <= r_busy;
            end

            // A new item starts, possibly in the cycle that finishes the
            // previous one; otherwise the sequencer walks the current item.
            if (accept) begin
                r_busy       <= 1'b1;
                r_col_sel    <= (pos_col != '0) ? COL_LEFT : COL_MID;
                r_row_sel    <= (pos_row != '0) ? ROW_UP : ROW_MID;
                r_prev_pixel <= i_item;
                if (32'(pos_col) + 32'd1 >= 32'(w_eff)) begin
                    r_src_col <= '0;
                    if (32'(pos_row) + 32'd1 >= 32'(h_eff)) begin
                        r_src_row <= '0;
                    end else begin
                        r_src_row <= pos_row + rgbup_pkg::ROW_W'(1);
                    end
                end else begin
                    r_src_col <= pos_col + rgbup_pkg::COL_W'(1);
                    r_src_row <= pos_row;
                end
            end else if (step) begin
                if (!row_last) begin
                    r_row_sel <= (r_row_sel == ROW_UP) ? ROW_MID : ROW_DOWN;
                end else if (!col_last) begin
                    r_col_sel <= (r_col_sel == COL_LEFT) ? COL_MID : COL_RIGHT;
                    r_row_sel <= row_first;
                end else begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Item and result payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cur         <= i_item;
            r_prev        <= r_prev_pixel;
            r_col         <= pos_col;
            r_row         <= pos_row;
            r_has_up      <= (pos_row != '0);
            r_is_last_col <= (32'(pos_col) + 32'd1 == 32'(w_eff));
            r_is_last_row <= (32'(pos_row) + 32'd1 == 32'(h_eff));
        end
        if (step) begin
            r_out <= result;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule

`default_nettype wire

/* sv/rgbup_checker.sv */
// Port-level checker for the 2x linear RGB upscaler and its bind to the top level.
`default_nettype none

module rgbup_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_valid,
    input wire logic                        o_stall,
    input wire logic                        o_valid,
    input wire logic                        i_stall,
    input wire rgbup_pkg::t_out_item        o_item
);

    // No result is offered right after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result offered right after reset");

    // A stalled result stays offered and unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item))
        else $error("stalled result changed or dropped");

    // An accepted item shows a result once the item registers and then the output register are loaded.
    a_first_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> ##1 o_valid)
        else $error("accepted item produced no result");

    // Results of one item follow each other without gaps.
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_item.run_last |=> o_valid)
        else $error("gap inside the results of one item");

endmodule

bind rgb_upscale_2x_linear rgbup_checker u_rgbup_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_item  (o_item)
);

`default_nettype wire
